// ----- rtl/core/assert_macros.svh -----
// Shared assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/core/srtf_pkg.sv -----
package srtf_pkg;

   // Action codes carried in a request word
   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   // Register file: one register, word-indexed by paddr[2]
   localparam int         CSR_ADDR_W    = 3;
   localparam logic       CSR_JOB_COUNT = 1'b0;
   localparam logic [4:0] JOB_COUNT_RST = 5'd1;

   localparam logic [19:0] TIME_MAX = 20'hFFFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  slot;
      logic [11:0] arrival;
      logic [11:0] burst;
   } req_word_type;

   typedef struct packed {
      logic        ran;
      logic [3:0]  running_slot;
      logic        finished;
      logic [19:0] finish_time;
      logic [19:0] turnaround;
      logic [19:0] waiting;
      logic [19:0] now_time;
      logic        all_done;
   } rsp_word_type;

   // One job table entry as held in the RAM
   typedef struct packed {
      logic [11:0] arrival;
      logic [11:0] burst;
      logic [11:0] remaining;
   } job_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_SCAN,
      ST_UPD,
      ST_FIN,
      ST_OUT
   } state_type;

   // Sequencer to compare unit
   typedef struct packed {
      logic        clear;
      logic        cand_valid;
      logic        cand_done;
      logic [19:0] now;
   } sel_ctrl_type;

   // Compare unit to sequencer
   typedef struct packed {
      logic        found;
      logic        none_pending;
      logic        one_pending;
      logic [11:0] best_arrival;
      logic [11:0] best_burst;
      logic [11:0] best_remaining;
   } sel_status_type;

endpackage

// ----- rtl/core/srtf_ram.sv -----
module srtf_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/srtf_select.sv -----
`include "assert_macros.svh"

module srtf_select #(
   parameter int MAX_JOBS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srtf_pkg::sel_ctrl_type        ctrl,
   input  logic [$clog2(MAX_JOBS)-1:0]   cand_idx,
   input  srtf_pkg::job_entry_type       cand,
   output srtf_pkg::sel_status_type      status,
   output logic [$clog2(MAX_JOBS)-1:0]   best_idx
);

   localparam int AW = $clog2(MAX_JOBS);
   localparam int CW = $clog2(MAX_JOBS + 1);

   logic          found_ff, found_in;
   logic [CW-1:0] pend_cnt_ff, pend_cnt_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   srtf_pkg::job_entry_type best_ff, best_in;
   logic          eligible;
   logic          better;

   // Shared compare: arrived and pending, then least remaining, first slot wins ties
   assign eligible = !ctrl.cand_done && ({8'd0, cand.arrival} <= ctrl.now);
   assign better   = eligible && (!found_ff || (cand.remaining < best_ff.remaining));

   always_comb begin
      found_in    = found_ff;
      pend_cnt_in = pend_cnt_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      if (ctrl.clear) begin
         found_in    = 1'b0;
         pend_cnt_in = '0;
      end else if (ctrl.cand_valid) begin
         if (!ctrl.cand_done) begin
            pend_cnt_in = pend_cnt_ff + CW'(1);
         end
         if (better) begin
            found_in    = 1'b1;
            best_idx_in = cand_idx;
            best_in     = cand;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         pend_cnt_ff <= '0;
      end else begin
         found_ff    <= found_in;
         pend_cnt_ff <= pend_cnt_in;
      end
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

   assign status.found          = found_ff;
   assign status.none_pending   = (pend_cnt_ff == '0);
   assign status.one_pending    = (pend_cnt_ff == CW'(1));
   assign status.best_arrival   = best_ff.arrival;
   assign status.best_burst     = best_ff.burst;
   assign status.best_remaining = best_ff.remaining;
   assign best_idx              = best_idx_ff;

   // A chosen job is always counted as pending
   `ASSERT_CLK(a_found_is_pending, clock, reset, found_ff |-> (pend_cnt_ff != '0), "best job without pending count")

endmodule

// ----- rtl/core/srtf_preemptive_scheduler.sv -----
// Shortest-remaining-time-first scheduler over a table of MAX_JOBS job slots.
// Request channel (req_valid/req_ready/req_word): a load word writes one slot's
// arrival and burst, a tick word serves the pending arrived job with the least
// remaining time for one time unit, a restart word zeroes time and re-arms
// every loaded job. Every request word gives exactly one response word on the
// rsp_ channel with the served slot, completion figures, time and all_done.
// job_count is written over the csr_ APB port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Flow: a restart first runs a rewrite sweep over all MAX_JOBS slots; every
// word then scans the slots in use through the compare unit, a tick that
// serves a job goes on to the update state, and to the finish state when the
// job completes, and the result goes out through the output state. The
// single job RAM read port is scanned one slot per cycle; one word is in work
// at a time, so a new word is accepted only once the block is idle again.
// Reset: synchronous, active high; all slots read as done, time is zero and
// job_count is one. The job RAM is not cleared: an unloaded slot is read only
// while marked done, so its contents are never used.
// Stall: the response register holds its word until rsp_ready; a new request
// is accepted meanwhile, and its result waits until that register is free.
`include "assert_macros.svh"

module srtf_preemptive_scheduler #(
   parameter int MAX_JOBS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  srtf_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output srtf_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [srtf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = $clog2(MAX_JOBS);
   localparam int CW = $clog2(MAX_JOBS + 1);
   localparam int EW = $bits(srtf_pkg::job_entry_type);

   srtf_pkg::state_type state_ff, state_in;

   logic [4:0]          job_count_ff;
   logic [CW-1:0]       rd_idx_ff, rd_idx_in;
   logic                pipe_valid_ff, pipe_valid_in;
   logic [AW-1:0]       cand_idx_ff, cand_idx_in;
   logic [1:0]          action_ff, action_in;
   logic [19:0]         time_ff, time_in;
   logic [MAX_JOBS-1:0] done_ff, done_in;
   logic [MAX_JOBS-1:0] loaded_ff, loaded_in;
   logic                res_ran_ff, res_ran_in;
   logic                res_fin_ff, res_fin_in;
   logic                res_all_done_ff, res_all_done_in;
   logic [19:0]         turn_ff, turn_in;
   logic [19:0]         wait_ff, wait_in;
   logic                rsp_valid_ff, rsp_valid_in;
   srtf_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   srtf_pkg::job_entry_type ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [EW-1:0]       ram_rd_bits;
   srtf_pkg::job_entry_type ram_rd_data;

   srtf_pkg::sel_ctrl_type   sel_ctrl;
   srtf_pkg::sel_status_type sel_status;
   logic [AW-1:0]       best_idx;

   logic [CW-1:0]       n_use;
   logic                scan_clear;
   logic                slot_ok;
   logic [AW-1:0]       slot_idx;
   logic [11:0]         load_burst;
   logic [11:0]         rem_next;
   logic                csr_wr;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == srtf_pkg::CSR_JOB_COUNT) ?
                       {27'd0, job_count_ff} : 32'd0;

   // Slots in use, clamped to the table size
   always_comb begin
      if (32'(job_count_ff) > 32'(MAX_JOBS)) begin
         n_use = CW'(MAX_JOBS);
      end else begin
         n_use = CW'(job_count_ff);
      end
   end

   assign slot_ok    = 32'(req_word.slot) < 32'(MAX_JOBS);
   assign slot_idx   = AW'(req_word.slot);
   assign load_burst = (req_word.burst == 12'd0) ? 12'd1 : req_word.burst;
   assign rem_next   = (sel_status.best_remaining == 12'd0) ? 12'd0 :
                       sel_status.best_remaining - 12'd1;

   // Job table
   srtf_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (EW'(ram_wr_data)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = srtf_pkg::job_entry_type'(ram_rd_bits);

   // Compare unit
   assign sel_ctrl.clear      = scan_clear;
   assign sel_ctrl.cand_valid = pipe_valid_ff && (state_ff == srtf_pkg::ST_SCAN);
   assign sel_ctrl.cand_done  = done_ff[cand_idx_ff];
   assign sel_ctrl.now        = time_ff;

   srtf_select #(
      .MAX_JOBS (MAX_JOBS)
   ) u_select (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sel_ctrl),
      .cand_idx (cand_idx_ff),
      .cand     (ram_rd_data),
      .status   (sel_status),
      .best_idx (best_idx)
   );

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srtf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      rd_idx_in       = rd_idx_ff;
      pipe_valid_in   = 1'b0;
      cand_idx_in     = cand_idx_ff;
      action_in       = action_ff;
      time_in         = time_ff;
      done_in         = done_ff;
      loaded_in       = loaded_ff;
      res_ran_in      = res_ran_ff;
      res_fin_in      = res_fin_ff;
      res_all_done_in = res_all_done_ff;
      turn_in         = turn_ff;
      wait_in         = wait_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_word_in     = rsp_word_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = '0;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = rd_idx_ff[AW-1:0];
      scan_clear      = 1'b0;
      req_ready       = 1'b0;

      unique case (state_ff)
         srtf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = req_word.action;
               rd_idx_in = '0;
               priority if (req_word.action == srtf_pkg::ACT_LOAD) begin
                  if (slot_ok) begin
                     ram_wr_en           = 1'b1;
                     ram_wr_addr         = slot_idx;
                     ram_wr_data.arrival   = req_word.arrival;
                     ram_wr_data.burst     = load_burst;
                     ram_wr_data.remaining = load_burst;
                     done_in[slot_idx]   = 1'b0;
                     loaded_in[slot_idx] = 1'b1;
                  end
                  scan_clear = 1'b1;
                  state_in   = srtf_pkg::ST_SCAN;
               end else if (req_word.action == srtf_pkg::ACT_RESTART) begin
                  time_in  = '0;
                  done_in  = done_ff & ~loaded_ff;
                  state_in = srtf_pkg::ST_SWEEP;
               end else begin
                  scan_clear = 1'b1;
                  state_in   = srtf_pkg::ST_SCAN;
               end
            end
         end

         // Rewrite remaining = burst for every loaded slot, read then write back
         srtf_pkg::ST_SWEEP: begin
            if (rd_idx_ff < CW'(MAX_JOBS)) begin
               ram_rd_en     = 1'b1;
               pipe_valid_in = 1'b1;
               cand_idx_in   = rd_idx_ff[AW-1:0];
               rd_idx_in     = rd_idx_ff + CW'(1);
            end
            if (pipe_valid_ff && loaded_ff[cand_idx_ff]) begin
               ram_wr_en             = 1'b1;
               ram_wr_addr           = cand_idx_ff;
               ram_wr_data.arrival   = ram_rd_data.arrival;
               ram_wr_data.burst     = ram_rd_data.burst;
               ram_wr_data.remaining = ram_rd_data.burst;
            end
            if ((rd_idx_ff == CW'(MAX_JOBS)) && !pipe_valid_ff) begin
               rd_idx_in  = '0;
               scan_clear = 1'b1;
               state_in   = srtf_pkg::ST_SCAN;
            end
         end

         // One slot per cycle through the compare unit
         srtf_pkg::ST_SCAN: begin
            if (rd_idx_ff < n_use) begin
               ram_rd_en     = 1'b1;
               pipe_valid_in = 1'b1;
               cand_idx_in   = rd_idx_ff[AW-1:0];
               rd_idx_in     = rd_idx_ff + CW'(1);
            end
            if ((rd_idx_ff == n_use) && !pipe_valid_ff) begin
               res_ran_in      = 1'b0;
               res_fin_in      = 1'b0;
               turn_in         = '0;
               wait_in         = '0;
               res_all_done_in = sel_status.none_pending;
               state_in        = srtf_pkg::ST_OUT;
               if ((action_ff == srtf_pkg::ACT_TICK) && !sel_status.none_pending) begin
                  time_in = (time_ff == srtf_pkg::TIME_MAX) ? time_ff : time_ff + 20'd1;
                  if (sel_status.found) begin
                     state_in = srtf_pkg::ST_UPD;
                  end
               end
            end
         end

         // Serve the chosen job for one unit
         srtf_pkg::ST_UPD: begin
            ram_wr_en             = 1'b1;
            ram_wr_addr           = best_idx;
            ram_wr_data.arrival   = sel_status.best_arrival;
            ram_wr_data.burst     = sel_status.best_burst;
            ram_wr_data.remaining = rem_next;
            res_ran_in            = 1'b1;
            if (rem_next == 12'd0) begin
               done_in[best_idx] = 1'b1;
               res_fin_in        = 1'b1;
               res_all_done_in   = sel_status.one_pending;
               turn_in = (time_ff > {8'd0, sel_status.best_arrival}) ?
                         time_ff - {8'd0, sel_status.best_arrival} : 20'd0;
               state_in = srtf_pkg::ST_FIN;
            end else begin
               res_all_done_in = 1'b0;
               state_in        = srtf_pkg::ST_OUT;
            end
         end

         // Waiting time from turnaround
         srtf_pkg::ST_FIN: begin
            wait_in = (turn_ff > {8'd0, sel_status.best_burst}) ?
                      turn_ff - {8'd0, sel_status.best_burst} : 20'd0;
            state_in = srtf_pkg::ST_OUT;
         end

         // Hand the result to the response register once it is free
         srtf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.ran          = res_ran_ff;
               rsp_word_in.running_slot = res_ran_ff ? 4'(best_idx) : 4'd0;
               rsp_word_in.finished     = res_fin_ff;
               rsp_word_in.finish_time  = res_fin_ff ? time_ff : 20'd0;
               rsp_word_in.turnaround   = turn_ff;
               rsp_word_in.waiting      = wait_ff;
               rsp_word_in.now_time     = time_ff;
               rsp_word_in.all_done     = res_all_done_ff;
               state_in                 = srtf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = srtf_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff  <= srtf_pkg::JOB_COUNT_RST;
         rd_idx_ff     <= '0;
         pipe_valid_ff <= 1'b0;
         time_ff       <= '0;
         done_ff       <= '1;
         loaded_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr && (csr_paddr[2] == srtf_pkg::CSR_JOB_COUNT)) begin
            job_count_ff <= csr_pwdata[4:0];
         end
         rd_idx_ff     <= rd_idx_in;
         pipe_valid_ff <= pipe_valid_in;
         time_ff       <= time_in;
         done_ff       <= done_in;
         loaded_ff     <= loaded_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cand_idx_ff     <= cand_idx_in;
      action_ff       <= action_in;
      res_ran_ff      <= res_ran_in;
      res_fin_ff      <= res_fin_in;
      res_all_done_ff <= res_all_done_in;
      turn_ff         <= turn_in;
      wait_ff         <= wait_in;
      rsp_word_ff     <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A response only appears out of the output state
   `ASSERT_CLK(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == srtf_pkg::ST_OUT), "response raised outside output state")
   // A served job always has time left
   `ASSERT_CLK(a_serve_nonzero, clock, reset, (state_ff == srtf_pkg::ST_UPD) |-> (sel_status.best_remaining != 12'd0), "served job with no time left")
   // Time only steps by one or restarts at zero
   `ASSERT_CLK(a_time_step, clock, reset, (time_ff != $past(time_ff)) |-> ((time_ff == 20'($past(time_ff) + 20'd1)) || (time_ff == 20'd0)), "time jumped")
   // Completion is only reported for a served job
   `ASSERT_CLK(a_fin_needs_ran, clock, reset, rsp_valid_ff |-> (rsp_word_ff.ran || !rsp_word_ff.finished), "finished without ran")

endmodule
